>>> sv/tdq_pkg.sv
// ----------------------------------------------------------------------------
// tdq_pkg: shared types for the thread deque
// Operation and status codes, controller command and datapath status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tdq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int HANDLE_BITS_DEF = 16;

  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_REMOVE     = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_BACK  = 2'd0,
    RD_FRONT = 2'd1,
    RD_NEXT  = 2'd2,
    RD_NEXT2 = 2'd3
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_BACK  = 2'd0,
    WR_FRONT = 2'd1,
    WR_POS   = 2'd2
  } wr_sel_t;

  typedef enum logic [1:0] {
    POS_HOLD = 2'd0,
    POS_CLR  = 2'd1,
    POS_INC  = 2'd2
  } pos_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_t;

  typedef enum logic [1:0] {
    FR_HOLD = 2'd0,
    FR_DEC  = 2'd1,
    FR_INC  = 2'd2
  } front_op_t;

  typedef struct packed {
    logic      latch_in;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_en;
    wr_sel_t   wr_sel;
    pos_op_t   pos_op;
    cnt_op_t   cnt_op;
    front_op_t front_op;
    logic      res_load;
    logic      res_take;
    status_t   res_status;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  match;
    logic  pos_last;
    logic  shift_last;
    logic  out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> sv/tdq_ctrl.sv
// ----------------------------------------------------------------------------
// tdq_ctrl: deque operation sequencer
// Steps each operation through the decode, memory read, search, shift and output phases it needs.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tdq_pkg::stat_t  stat,
  output tdq_pkg::cmd_t        cmd
);
  import tdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SRCH,
    S_SHIFT,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RD_FRONT;
    cmd.wr_sel     = WR_BACK;
    cmd.pos_op     = POS_HOLD;
    cmd.cnt_op     = CNT_HOLD;
    cmd.front_op   = FR_HOLD;
    cmd.res_status = ST_OK;
    state_nxt      = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.latch_in = in_valid & in_ready_r;
        if (in_valid & in_ready_r) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.mode)
          MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
            cmd.res_load = 1'b1;
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.cnt_op = CNT_INC;
              if (stat.mode == MODE_PUSH_FRONT) begin
                cmd.wr_sel   = WR_FRONT;
                cmd.front_op = FR_DEC;
              end
            end
            state_nxt = S_OUT;
          end
          MODE_POP_BACK, MODE_POP_FRONT: begin
            if (stat.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_nxt      = S_OUT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = (stat.mode == MODE_POP_BACK) ? RD_BACK : RD_FRONT;
              state_nxt  = S_POP;
            end
          end
          MODE_REMOVE: begin
            if (stat.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_NOT_FOUND;
              state_nxt      = S_OUT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_FRONT;
              cmd.pos_op = POS_CLR;
              state_nxt  = S_SRCH;
            end
          end
          default: begin
            // unused codes: plain ok result, no change
            cmd.res_load = 1'b1;
            state_nxt    = S_OUT;
          end
        endcase
      end
      S_POP: begin
        cmd.res_load = 1'b1;
        cmd.res_take = 1'b1;
        cmd.cnt_op   = CNT_DEC;
        if (stat.mode == MODE_POP_FRONT) begin
          cmd.front_op = FR_INC;
        end
        state_nxt = S_OUT;
      end
      S_SRCH: begin
        if (stat.match) begin
          cmd.res_load = 1'b1;
          cmd.res_take = 1'b1;
          if (stat.pos_last) begin
            cmd.cnt_op = CNT_DEC;
            state_nxt  = S_OUT;
          end else begin
            // fetch the follower; pos stays on the hole
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT;
            state_nxt  = S_SHIFT;
          end
        end else if (stat.pos_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_nxt      = S_OUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          cmd.pos_op = POS_INC;
        end
      end
      S_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_POS;
        cmd.pos_op = POS_INC;
        if (stat.shift_last) begin
          cmd.cnt_op = CNT_DEC;
          state_nxt  = S_OUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT2;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/tdq_dp.sv
// ----------------------------------------------------------------------------
// tdq_dp: deque datapath
// Circular entry memory, front pointer, entry count, scan position and the
// result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_dp #(
  parameter int DEPTH       = tdq_pkg::DEPTH_DEF,
  parameter int ID_BITS     = tdq_pkg::ID_BITS_DEF,
  parameter int HANDLE_BITS = tdq_pkg::HANDLE_BITS_DEF,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [2:0]             in_mode,
  input  wire logic [ID_BITS-1:0]     in_id,
  input  wire logic [HANDLE_BITS-1:0] in_handle,
  input  wire tdq_pkg::cmd_t          cmd,
  output tdq_pkg::stat_t              stat,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ID_BITS-1:0]          out_id,
  output logic [HANDLE_BITS-1:0]      out_handle,
  output logic [1:0]                  out_status,
  output logic [CW-1:0]               out_occ
);
  import tdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = ID_BITS + HANDLE_BITS;
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

  logic [EW-1:0]          mem [DEPTH];
  logic [EW-1:0]          rdata_r;

  logic [2:0]             mode_r;
  logic [ID_BITS-1:0]     id_r;
  logic [HANDLE_BITS-1:0] hd_r;

  logic [AW-1:0]          front_r;
  logic [AW-1:0]          front_nxt;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic [CW-1:0]          pos_r;
  logic [CW-1:0]          pos_nxt;
  logic                   out_valid_r;

  logic [ID_BITS-1:0]     res_id_r;
  logic [HANDLE_BITS-1:0] res_hd_r;
  logic [1:0]             res_status_r;

  logic [ID_BITS-1:0]     out_id_r;
  logic [HANDLE_BITS-1:0] out_hd_r;
  logic [1:0]             out_status_r;
  logic [CW-1:0]          out_occ_r;

  logic [CW:0]            cnt_x;
  logic [CW:0]            pos_x;
  logic [AW-1:0]          front_m1;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [EW-1:0]          wr_data;

  // position relative to front, wrapped onto the circular store
  function automatic logic [AW-1:0] cell_of(input logic [AW-1:0] f, input logic [CW:0] x);
    logic [CW:0] s;
    s = (CW + 1)'(f) + x;
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  assign cnt_x    = {1'b0, count_r};
  assign pos_x    = {1'b0, pos_r};
  assign front_m1 = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_BACK:  rd_addr = cell_of(front_r, cnt_x - (CW + 1)'(1));
      RD_FRONT: rd_addr = front_r;
      RD_NEXT:  rd_addr = cell_of(front_r, pos_x + (CW + 1)'(1));
      RD_NEXT2: rd_addr = cell_of(front_r, pos_x + (CW + 1)'(2));
      default:  rd_addr = front_r;
    endcase
  end

  always_comb begin
    wr_data = {hd_r, id_r};
    case (cmd.wr_sel)
      WR_BACK:  wr_addr = cell_of(front_r, cnt_x);
      WR_FRONT: wr_addr = front_m1;
      WR_POS: begin
        wr_addr = cell_of(front_r, pos_x);
        wr_data = rdata_r;
      end
      default:  wr_addr = cell_of(front_r, cnt_x);
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_nxt = count_r + CW'(1);
      CNT_DEC: count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
    case (cmd.pos_op)
      POS_CLR: pos_nxt = '0;
      POS_INC: pos_nxt = pos_r + CW'(1);
      default: pos_nxt = pos_r;
    endcase
    case (cmd.front_op)
      FR_DEC:  front_nxt = front_m1;
      FR_INC:  front_nxt = cell_of(front_r, (CW + 1)'(1));
      default: front_nxt = front_r;
    endcase
  end

  always_comb begin
    stat.mode       = mode_t'(mode_r);
    stat.full       = (count_r == CW'(DEPTH));
    stat.empty      = (count_r == '0);
    stat.match      = (rdata_r[ID_BITS-1:0] == id_r);
    stat.pos_last   = (pos_x + (CW + 1)'(1) >= cnt_x);
    stat.shift_last = (pos_x + (CW + 1)'(2) >= cnt_x);
    stat.out_free   = ~out_valid_r | out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode_r <= in_mode;
      id_r   <= in_id;
      hd_r   <= in_handle;
    end
    if (cmd.res_load) begin
      res_id_r     <= cmd.res_take ? rdata_r[ID_BITS-1:0] : '0;
      res_hd_r     <= cmd.res_take ? rdata_r[EW-1:ID_BITS] : '0;
      res_status_r <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_id_r     <= res_id_r;
      out_hd_r     <= res_hd_r;
      out_status_r <= res_status_r;
      out_occ_r    <= count_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_handle = out_hd_r;
  assign out_status = out_status_r;
  assign out_occ    = out_occ_r;

endmodule

`default_nettype wire

>>> sv/thread_deque_with_remove_by_id.sv
// ----------------------------------------------------------------------------
// thread_deque_with_remove_by_id: bounded deque of thread entries
// Each input beat carries one operation (push back, push front, pop back,
// pop front, remove first entry with a given id); each gives one result beat.
// Input channel: in_tuser holds the mode, in_tdata the id and handle.
// Output channel: out_tdata holds id, handle and occupancy after the
// operation, out_tuser the status (ok, empty, full, not found).
// Entries sit in a circular memory of DEPTH cells with one write and one
// registered read port; operations run one at a time through a sequencer.
// Pushes, failed pops and unused modes go from decode straight to the result
// step; a pop adds one memory read, and a remove one memory read per scanned
// entry plus one read and write per entry moved up to close the gap; a new
// beat can be taken the cycle after the result enters the output register.
// Reset empties the deque; memory contents are not cleared.
// A stalled receiver holds the result in the output register; the next beat
// is still accepted and its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module thread_deque_with_remove_by_id #(
  parameter int DEPTH       = tdq_pkg::DEPTH_DEF,
  parameter int ID_BITS     = tdq_pkg::ID_BITS_DEF,
  parameter int HANDLE_BITS = tdq_pkg::HANDLE_BITS_DEF,
  localparam int CW         = $clog2(DEPTH + 1),
  localparam int IN_TW      = ((ID_BITS + HANDLE_BITS + 7) / 8) * 8,
  localparam int OUT_TW     = ((ID_BITS + HANDLE_BITS + CW + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_TW-1:0]  in_tdata,   // thread_id, handle
  input  wire logic [2:0]        in_tuser,   // mode
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_TW-1:0]      out_tdata,  // out_id, out_handle, occupancy
  output logic [1:0]             out_tuser   // status
);
  import tdq_pkg::*;

  cmd_t                   cmd;
  stat_t                  stat;
  logic [ID_BITS-1:0]     out_id;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [CW-1:0]          out_occ;

  tdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tdq_dp #(
    .DEPTH       (DEPTH),
    .ID_BITS     (ID_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mode    (in_tuser),
    .in_id      (in_tdata[ID_BITS-1:0]),
    .in_handle  (in_tdata[ID_BITS +: HANDLE_BITS]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_id     (out_id),
    .out_handle (out_handle),
    .out_status (out_tuser),
    .out_occ    (out_occ)
  );

  assign out_tdata = OUT_TW'({out_occ, out_handle, out_id});

endmodule

`default_nettype wire

>>> tb/sv/thread_deque_with_remove_by_id_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_deque_with_remove_by_id_tb: self-checking bench for the thread deque
// A table of directed operations (empty pops, full push, unused modes,
// extreme ids and handles, duplicate-id removal) is followed by random
// operation streams that sweep the deque between empty and full. Every
// accepted beat is run through a local deque model, and each result beat is
// compared field by field with the oldest pending prediction. Both channels
// idle at random, and the receiver holds off once for a long stretch so the
// block backs up and stalls its input.
// ----------------------------------------------------------------------------

module thread_deque_with_remove_by_id_tb;
  import tdq_pkg::*;

  localparam int DEPTH       = tdq_pkg::DEPTH_DEF;
  localparam int RAND_OPS    = 890;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic [15:0] ent_id;
    logic [15:0] ent_hd;
    status_t     st;
    logic [4:0]  occ;
  } deque_res_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] id;
    logic [15:0] hd;
    logic        typed;
    deque_res_t  want;
  } op_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // thread_id, handle
  logic [2:0]  in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // out_id, out_handle, occupancy
  logic [1:0]  out_tuser;  // status

  // local copy of the deque
  logic [15:0] ent_ids [DEPTH];
  logic [15:0] ent_hds [DEPTH];
  logic [3:0]  q_front;
  logic [4:0]  q_count;

  deque_res_t pending_results[$];
  op_row_t    op_table[$];

  int  errors;
  int  beats_taken;
  int  cycles;
  bit  send_quiet;
  bit  recv_quiet;
  bit  long_hold_done;
  bit  filling;
  int  row_idx;
  int  real_ops;
  int  pick;
  logic [2:0]  op_mode;
  logic [15:0] op_id;

  thread_deque_with_remove_by_id uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch at result beat %0d: %s got %h expected %h",
               beats_taken, what, got, want);
  endtask

  // applies one operation to the local deque and returns its result
  function automatic deque_res_t deque_apply(input logic [2:0] mode,
                                             input logic [15:0] id,
                                             input logic [15:0] hd);
    deque_res_t r;
    logic [3:0] slot;
    logic [3:0] src;
    int         pos;
    r = '0;
    r.st = ST_OK;
    case (mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (q_count == DEPTH) begin
          r.st = ST_FULL;
        end else begin
          if (mode == MODE_PUSH_BACK) begin
            slot = q_front + q_count[3:0];
          end else begin
            q_front = q_front - 4'd1;
            slot = q_front;
          end
          ent_ids[slot] = id;
          ent_hds[slot] = hd;
          q_count = q_count + 5'd1;
        end
      end
      MODE_POP_BACK, MODE_POP_FRONT: begin
        if (q_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          if (mode == MODE_POP_BACK) begin
            slot = q_front + q_count[3:0] - 4'd1;
          end else begin
            slot = q_front;
            q_front = q_front + 4'd1;
          end
          r.ent_id = ent_ids[slot];
          r.ent_hd = ent_hds[slot];
          q_count = q_count - 5'd1;
        end
      end
      MODE_REMOVE: begin
        pos = -1;
        for (int k = 0; k < q_count; k++) begin
          slot = q_front + k[3:0];
          if (pos < 0 && ent_ids[slot] == id) pos = k;
        end
        if (pos < 0) begin
          r.st = ST_NOT_FOUND;
        end else begin
          slot = q_front + pos[3:0];
          r.ent_id = ent_ids[slot];
          r.ent_hd = ent_hds[slot];
          // close the gap toward the front
          for (int k = pos; k + 1 < q_count; k++) begin
            slot = q_front + k[3:0];
            src = q_front + k[3:0] + 4'd1;
            ent_ids[slot] = ent_ids[src];
            ent_hds[slot] = ent_hds[src];
          end
          q_count = q_count - 5'd1;
        end
      end
      default: ;
    endcase
    r.occ = q_count;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] mode, input logic [15:0] id,
                         input logic [15:0] hd, input logic typed,
                         input logic [15:0] eid, input logic [15:0] ehd,
                         input status_t est, input logic [4:0] eocc);
    op_row_t row;
    row.mode = mode;
    row.id = id;
    row.hd = hd;
    row.typed = typed;
    row.want.ent_id = eid;
    row.want.ent_hd = ehd;
    row.want.st = est;
    row.want.occ = eocc;
    op_table.push_back(row);
  endtask

  // offers one beat after a random gap; called at a rising edge
  task automatic send_op(input logic [2:0] mode, input logic [15:0] id,
                         input logic [15:0] hd, input logic typed,
                         input deque_res_t want);
    int gap;
    deque_res_t pred;
    gap = send_quiet ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 99) < 3) send_quiet = !send_quiet;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {hd, id};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    pred = deque_apply(mode, id, hd);
    pending_results.push_back(typed ? want : pred);
  endtask

  // result checker, samples mid-cycle where all signals are settled
  always @(negedge clk) begin
    deque_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("beat with nothing pending", out_tdata[31:0], 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[15:0] !== want.ent_id)
          report_mismatch("out_id", 32'(out_tdata[15:0]), 32'(want.ent_id));
        if (out_tdata[31:16] !== want.ent_hd)
          report_mismatch("out_handle", 32'(out_tdata[31:16]), 32'(want.ent_hd));
        if (out_tuser !== want.st)
          report_mismatch("status", 32'(out_tuser), 32'(want.st));
        if (out_tdata[36:32] !== want.occ)
          report_mismatch("occupancy", 32'(out_tdata[36:32]), 32'(want.occ));
      end
      beats_taken++;
    end
  end

  // receiver: random holds per beat, one long hold-off to back up the block
  initial begin : drain
    int hold;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!long_hold_done && beats_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold = HOLD_CYCLES;
      end else begin
        hold = recv_quiet ? 0 : $urandom_range(0, 15);
      end
      if ($urandom_range(0, 99) < 3) recv_quiet = !recv_quiet;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (!out_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    errors = 0;
    beats_taken = 0;
    cycles = 0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    long_hold_done = 1'b0;
    filling = 1'b1;
    q_front = '0;
    q_count = '0;

    // empty deque, unused mode, extremes of id and handle
    add_row(MODE_POP_BACK, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_EMPTY, 5'd0);
    add_row(MODE_POP_FRONT, 16'hffff, 16'hffff, 1'b1, 16'h0000, 16'h0000, ST_EMPTY, 5'd0);
    add_row(MODE_REMOVE, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_NOT_FOUND, 5'd0);
    add_row(3'd7, 16'hffff, 16'hffff, 1'b1, 16'h0000, 16'h0000, ST_OK, 5'd0);
    add_row(MODE_PUSH_BACK, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_OK, 5'd1);
    add_row(MODE_PUSH_FRONT, 16'hffff, 16'hffff, 1'b1, 16'h0000, 16'h0000, ST_OK, 5'd2);
    add_row(MODE_POP_BACK, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_OK, 5'd1);
    add_row(MODE_POP_FRONT, 16'h0000, 16'h0000, 1'b1, 16'hffff, 16'hffff, ST_OK, 5'd0);
    // fill from both ends with repeating ids
    for (int k = 0; k < DEPTH; k++)
      add_row(k[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, 16'(k % 4), {4{k[3:0]}}, 1'b0,
              16'h0000, 16'h0000, ST_OK, 5'd0);
    add_row(MODE_PUSH_BACK, 16'h1234, 16'h5678, 1'b1, 16'h0000, 16'h0000, ST_FULL, 5'd16);
    add_row(MODE_REMOVE, 16'hbeef, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_NOT_FOUND, 5'd16);
    add_row(MODE_REMOVE, 16'd2, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK, 5'd0);
    add_row(MODE_REMOVE, 16'd3, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK, 5'd0);
    add_row(MODE_POP_FRONT, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK, 5'd0);
    add_row(MODE_POP_BACK, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK, 5'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row_idx = 0; row_idx < op_table.size(); row_idx++)
      send_op(op_table[row_idx].mode, op_table[row_idx].id, op_table[row_idx].hd,
              op_table[row_idx].typed, op_table[row_idx].want);

    // random streams drifting between fill and drain
    real_ops = 0;
    while (real_ops < RAND_OPS) begin
      if (q_count == DEPTH) filling = 1'b0;
      else if (q_count == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) < 4) filling = !filling;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) op_id = 16'($urandom_range(0, 65535));
      else op_id = 16'($urandom_range(0, 7));
      if (pick < 3) op_mode = 3'($urandom_range(5, 7));
      else if (pick < 23) op_mode = MODE_REMOVE;
      else if (pick < (filling ? 73 : 50))
        op_mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      else
        op_mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
      if (op_mode <= MODE_REMOVE) real_ops++;
      send_op(op_mode, op_id, 16'($urandom_range(0, 65535)), 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> thread_deque_with_remove_by_id.f
sv/tdq_pkg.sv
sv/tdq_ctrl.sv
sv/tdq_dp.sv
sv/thread_deque_with_remove_by_id.sv
tb/sv/thread_deque_with_remove_by_id_tb.sv
